// File: hdl/joypad_matrix_register_assert.svh
// Assertion macros used by the joypad matrix register checker.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef JOYPAD_MATRIX_REGISTER_ASSERT_SVH
`define JOYPAD_MATRIX_REGISTER_ASSERT_SVH

// Same-cycle implication.
`define JMR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jmr check failed: same-cycle implication");

// Next-cycle implication.
`define JMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jmr check failed: next-cycle implication");

`endif

// File: hdl/jmr_pkg.sv
package jmr_pkg;

    // Width of the tick distance counter
    localparam int CNT_W = 32;
    // Width of the sample interval register
    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] INTERVAL_RST = CFG_W'(10000);

    localparam logic [7:0] BUTTONS_RST = 8'hFF;
    localparam logic [3:0] NIBBLE_ONES = 4'hF;
    localparam logic [1:0] READ_HIGH   = 2'b11;

    // Stream widths
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_KEY   = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] write_data;
        logic [2:0] button;
        logic       pressed;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } result_t;

endpackage

// File: hdl/jmr_core.sv
module jmr_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [jmr_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                     en,
    input  jmr_pkg::item_t           item,
    output jmr_pkg::result_t         res
);
    import jmr_pkg::*;

    logic [7:0]       live_reg,     live_next;
    logic [7:0]       snap_reg,     snap_next;
    logic [1:0]       sel_reg,      sel_next;
    logic [3:0]       nib_reg,      nib_next;
    logic [CNT_W-1:0] elapsed_reg,  elapsed_next;
    logic             all_high_reg, all_high_next;
    logic [CFG_W-1:0] interval_reg;

    logic [CNT_W-1:0] elapsed_tick;
    logic [CNT_W-1:0] elapsed_use;
    logic [1:0]       sel_use;
    logic             refresh;
    logic [7:0]       snap_use;
    logic [3:0]       nib_new;
    logic             all_high_new;
    logic [7:0]       key_mask;

    // Ticks since last snapshot, advanced by one on a tick beat
    assign elapsed_tick = elapsed_reg + {{(CNT_W-1){1'b0}}, 1'b1};
    assign elapsed_use  = (item.func == FUNC_TICK) ? elapsed_tick : elapsed_reg;
    assign sel_use      = (item.func == FUNC_WRITE) ? item.write_data[5:4] : sel_reg;

    // Recompute: optional snapshot refresh, then rebuild nibble from selected rows
    assign refresh  = (elapsed_use >= CNT_W'(interval_reg));
    assign snap_use = refresh ? live_reg : snap_reg;

    always_comb
    begin
        nib_new = NIBBLE_ONES;
        if (!sel_use[1])
            nib_new = snap_use[7:4];
        if (!sel_use[0])
            nib_new = nib_new & snap_use[3:0];
    end

    assign all_high_new = (nib_new == NIBBLE_ONES);
    assign key_mask     = 8'(1) << item.button;

    // Next state and result for the beat in the input stage
    always_comb
    begin
        live_next     = live_reg;
        snap_next     = snap_reg;
        sel_next      = sel_reg;
        nib_next      = nib_reg;
        elapsed_next  = elapsed_reg;
        all_high_next = all_high_reg;
        res.read_data = 8'd0;
        res.irq       = 1'b0;
        unique case (item.func) inside
            FUNC_READ:
            begin
                snap_next     = live_reg;
                elapsed_next  = '0;
                res.read_data = {READ_HIGH, sel_reg, nib_reg};
            end
            FUNC_KEY:
            begin
                if (item.pressed)
                    live_next = live_reg & ~key_mask;
                else
                    live_next = live_reg | key_mask;
            end
            FUNC_WRITE, FUNC_TICK:
            begin
                snap_next     = snap_use;
                elapsed_next  = refresh ? '0 : elapsed_use;
                sel_next      = sel_use;
                nib_next      = nib_new;
                all_high_next = all_high_new;
                res.irq       = !all_high_new && all_high_reg;
            end
            default:
            begin
                live_next = live_reg;
            end
        endcase
    end

    // State registers, updated only when a beat leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= BUTTONS_RST;
            snap_reg     <= BUTTONS_RST;
            sel_reg      <= 2'b00;
            nib_reg      <= NIBBLE_ONES;
            elapsed_reg  <= '0;
            all_high_reg <= 1'b0;
        end
        else if (en)
        begin
            live_reg     <= live_next;
            snap_reg     <= snap_next;
            sel_reg      <= sel_next;
            nib_reg      <= nib_next;
            elapsed_reg  <= elapsed_next;
            all_high_reg <= all_high_next;
        end
    end

    // Sample interval register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interval_reg <= INTERVAL_RST;
        else if (cfg_we)
            interval_reg <= cfg_wdata;
    end

endmodule

// File: hdl/joypad_matrix_register.sv
// Joypad matrix register: eight active-low buttons read through two row
// selects and a four-bit nibble. Each input beat carries an operation in
// s_axis_tuser (read, write, key change, tick) and yields exactly one output
// beat (read_data, irq). A beat is registered in an input stage, processed by
// one pass of combinational logic into the output register, so one beat is
// taken every clock cycle while the output side keeps up; an accepted beat
// passes the input stage and then the output register before it is offered
// on the output side. The sample interval may only be written while no beat
// is in flight. There is no clearing pass after reset.
module joypad_matrix_register (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [jmr_pkg::CFG_W-1:0]      cfg_wdata,       // sample_interval
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [jmr_pkg::IN_DATA_W-1:0]  s_axis_tdata,    // write_data[7:0], button[10:8], pressed[11]
    input  logic [jmr_pkg::IN_USER_W-1:0]  s_axis_tuser,    // func[1:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [jmr_pkg::OUT_DATA_W-1:0] m_axis_tdata     // read_data[7:0], irq[8]
);
    import jmr_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg,  in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,  out_res_next;
    result_t core_res;
    logic    advance;
    logic    s_accept;
    item_t   s_item;

    assign s_item.func       = func_t'(s_axis_tuser);
    assign s_item.write_data = s_axis_tdata[7:0];
    assign s_item.button     = s_axis_tdata[10:8];
    assign s_item.pressed    = s_axis_tdata[11];

    // Input stage moves to the output register when that register is empty or its beat is being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    jmr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .en        (advance),
        .item      (in_item_reg),
        .res       (core_res)
    );

    // Stage control
    always_comb
    begin
        in_valid_next  = s_accept || (in_valid_reg && !advance);
        in_item_next   = s_accept ? s_item : in_item_reg;
        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
        out_res_next   = advance ? core_res : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-9){1'b0}}, out_res_reg.irq, out_res_reg.read_data};

endmodule

// File: hdl/jmr_checker.sv
`include "joypad_matrix_register_assert.svh"

module jmr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [jmr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import jmr_pkg::*;

    // A stalled output beat holds
    `JMR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // An interrupt only comes from a write or tick, never with read data
    `JMR_ASSERT_IMPL(a_irq_no_read, m_axis_tvalid && m_axis_tdata[8], m_axis_tdata[7:0] == 8'd0)

    // Read data always carries the two forced-high bits
    `JMR_ASSERT_IMPL(a_read_high, m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0), m_axis_tdata[7:6] == READ_HIGH)

    // Pad bits stay zero
    `JMR_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:9] == '0)

endmodule

bind joypad_matrix_register jmr_checker u_jmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
